// ----- hw/rtl/i2cm_pkg.sv -----
package i2cm_pkg;

  localparam logic [2:0] ACT_TICK      = 3'd0;
  localparam logic [2:0] ACT_START     = 3'd1;
  localparam logic [2:0] ACT_STOP      = 3'd2;
  localparam logic [2:0] ACT_WRITE     = 3'd3;
  localparam logic [2:0] ACT_READ_ACK  = 3'd4;
  localparam logic [2:0] ACT_READ_NACK = 3'd5;

  localparam logic [1:0] REG_SETUP_TICKS = 2'd0;
  localparam logic [1:0] REG_HIGH_TICKS  = 2'd1;
  localparam logic [1:0] REG_LOW_TICKS   = 2'd2;
  localparam logic [1:0] REG_ACK_TIMEOUT = 2'd3;

  localparam logic [7:0] SETUP_TICKS_RESET = 8'd1;
  localparam logic [7:0] HIGH_TICKS_RESET  = 8'd5;
  localparam logic [7:0] LOW_TICKS_RESET   = 8'd4;
  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // Phase codes of the bit sequencer.
  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_S_A    = 4'd1;   // start: both lines high
  localparam logic [3:0] PH_S_B    = 4'd2;   // start: SDA low, SCL high
  localparam logic [3:0] PH_P_A    = 4'd3;   // stop: both lines low
  localparam logic [3:0] PH_P_B    = 4'd4;   // stop: SCL high
  localparam logic [3:0] PH_W_SET  = 4'd5;
  localparam logic [3:0] PH_W_HI   = 4'd6;
  localparam logic [3:0] PH_W_LO   = 4'd7;
  localparam logic [3:0] PH_K_SET  = 4'd8;
  localparam logic [3:0] PH_K_WAIT = 4'd9;
  localparam logic [3:0] PH_F_A    = 4'd10;  // stop after a failed acknowledge
  localparam logic [3:0] PH_F_B    = 4'd11;
  localparam logic [3:0] PH_R_LO   = 4'd12;
  localparam logic [3:0] PH_R_HI   = 4'd13;
  localparam logic [3:0] PH_A_SET  = 4'd14;
  localparam logic [3:0] PH_A_HI   = 4'd15;

  typedef struct packed {
    logic [3:0] phase;
    logic [3:0] bit_count;
    logic [7:0] tick_count;
    logic [7:0] shift_reg;
    logic [7:0] wait_count;
    logic       scl_reg;
    logic       sda_reg;
    logic       sda_dir;
  } engine_state_t;

  typedef struct packed {
    logic [7:0] setup_ticks;
    logic [7:0] high_ticks;
    logic [7:0] low_ticks;
    logic [7:0] ack_timeout;
  } engine_cfg_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       ack_ok;
    logic [7:0] read_data;
    logic       rejected;
  } engine_result_t;

endpackage

// ----- hw/rtl/i2c_master_bit_engine_core.sv -----
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+-----------------------------------------
// input    | in        | in_valid / in_stall | action, data_byte, sda_in
// result   | out       | out_valid/out_stall | scl_level, sda_level, sda_drive, busy_res,
//          |           |                     | done_res, ack_ok, read_data, rejected
// config   | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// For every item, tick or command, the sequencer state and the result register are updated at the
// edge where the item is accepted, so one item per clock is sustained while the output is not stalled.
// The result appears in the output register the cycle after acceptance.
// Input stalls only while a result is held in the output register and the output is stalled.
// Synchronous reset sets the sequencer's SCL and SDA registers high with SDA driven, the sequencer idle
// and the configuration registers at their defaults. Configuration writes are always ready.
module i2c_master_bit_engine_core (
  input  logic       clk,
  input  logic       rst,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] action,
  input  logic [7:0] data_byte,
  input  logic       sda_in,

  output logic       out_valid,
  input  logic       out_stall,
  output logic       scl_level,
  output logic       sda_level,
  output logic       sda_drive,
  output logic       busy_res,
  output logic       done_res,
  output logic       ack_ok,
  output logic [7:0] read_data,
  output logic       rejected,

  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  i2cm_pkg::engine_state_t  state;
  i2cm_pkg::engine_state_t  state_next;
  i2cm_pkg::engine_cfg_t    cfg;
  i2cm_pkg::engine_result_t result_next;
  i2cm_pkg::engine_result_t result;
  logic                     in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  i2cm_step u_step (
    .state      (state),
    .cfg        (cfg),
    .action     (action),
    .data_byte  (data_byte),
    .sda_in     (sda_in),
    .state_next (state_next),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setup_ticks <= i2cm_pkg::SETUP_TICKS_RESET;
      cfg.high_ticks  <= i2cm_pkg::HIGH_TICKS_RESET;
      cfg.low_ticks   <= i2cm_pkg::LOW_TICKS_RESET;
      cfg.ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        i2cm_pkg::REG_SETUP_TICKS: cfg.setup_ticks <= cfg_data;
        i2cm_pkg::REG_HIGH_TICKS:  cfg.high_ticks  <= cfg_data;
        i2cm_pkg::REG_LOW_TICKS:   cfg.low_ticks   <= cfg_data;
        i2cm_pkg::REG_ACK_TIMEOUT: cfg.ack_timeout <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase      <= i2cm_pkg::PH_IDLE;
      state.bit_count  <= 4'd0;
      state.tick_count <= 8'd0;
      state.shift_reg  <= 8'd0;
      state.wait_count <= 8'd0;
      state.scl_reg    <= 1'b1;
      state.sda_reg    <= 1'b1;
      state.sda_dir    <= 1'b1;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      result <= result_next;
    end
  end

  assign scl_level = result.scl_level;
  assign sda_level = result.sda_level;
  assign sda_drive = result.sda_drive;
  assign busy_res  = result.busy_res;
  assign done_res  = result.done_res;
  assign ack_ok    = result.ack_ok;
  assign read_data = result.read_data;
  assign rejected  = result.rejected;

endmodule

// ----- hw/rtl/i2cm_step.sv -----
module i2cm_step (
  input  i2cm_pkg::engine_state_t  state,
  input  i2cm_pkg::engine_cfg_t    cfg,
  input  logic [2:0]               action,
  input  logic [7:0]               data_byte,
  input  logic                     sda_in,
  output i2cm_pkg::engine_state_t  state_next,
  output i2cm_pkg::engine_result_t result
);

  logic [7:0] dur;
  logic [7:0] dur_eff;
  logic [8:0] tick_inc;
  logic       over;
  logic [3:0] bit_inc;
  logic [7:0] wait_inc;
  logic [7:0] shift_w;
  logic [7:0] shift_r;
  logic       done;
  logic       ack;
  logic       rej;
  logic [7:0] rd;

  // Duration of the phase in progress; a zero register counts as one tick.
  always_comb begin
    unique case (state.phase)
      i2cm_pkg::PH_W_SET, i2cm_pkg::PH_K_SET, i2cm_pkg::PH_A_SET: dur = cfg.setup_ticks;
      i2cm_pkg::PH_W_LO, i2cm_pkg::PH_R_LO:                      dur = cfg.low_ticks;
      default:                                                   dur = cfg.high_ticks;
    endcase
  end

  assign dur_eff  = (dur == 8'd0) ? 8'd1 : dur;
  assign tick_inc = {1'b0, state.tick_count} + 9'd1;
  assign over     = tick_inc >= {1'b0, dur_eff};
  assign bit_inc  = state.bit_count + 4'd1;
  assign wait_inc = state.wait_count + 8'd1;
  assign shift_w  = {state.shift_reg[6:0], 1'b0};
  assign shift_r  = {state.shift_reg[6:0], sda_in};

  always_comb begin
    state_next = state;
    done       = 1'b0;
    ack        = 1'b0;
    rej        = 1'b0;
    rd         = 8'd0;

    if (action >= i2cm_pkg::ACT_START && action <= i2cm_pkg::ACT_READ_NACK) begin
      if (state.phase != i2cm_pkg::PH_IDLE) begin
        rej = 1'b1;
      end else begin
        state_next.tick_count = 8'd0;
        priority if (action == i2cm_pkg::ACT_START) begin
          state_next.sda_dir = 1'b1;
          state_next.sda_reg = 1'b1;
          state_next.scl_reg = 1'b1;
          state_next.phase   = i2cm_pkg::PH_S_A;
        end else if (action == i2cm_pkg::ACT_STOP) begin
          state_next.sda_dir = 1'b1;
          state_next.sda_reg = 1'b0;
          state_next.scl_reg = 1'b0;
          state_next.phase   = i2cm_pkg::PH_P_A;
        end else if (action == i2cm_pkg::ACT_WRITE) begin
          state_next.sda_dir   = 1'b1;
          state_next.scl_reg   = 1'b0;
          state_next.shift_reg = data_byte;
          state_next.bit_count = 4'd0;
          state_next.sda_reg   = data_byte[7];
          state_next.phase     = i2cm_pkg::PH_W_SET;
        end else begin
          state_next.sda_dir    = 1'b0;
          state_next.sda_reg    = 1'b1;
          state_next.scl_reg    = 1'b0;
          state_next.shift_reg  = 8'd0;
          state_next.bit_count  = 4'd0;
          // The low bit of the wait counter carries the ACK/NACK choice for reads.
          state_next.wait_count = {7'd0, action == i2cm_pkg::ACT_READ_NACK};
          state_next.phase      = i2cm_pkg::PH_R_LO;
        end
      end
    end else if (action == i2cm_pkg::ACT_TICK) begin
      if (state.phase != i2cm_pkg::PH_IDLE && state.phase != i2cm_pkg::PH_K_WAIT) begin
        state_next.tick_count = over ? 8'd0 : tick_inc[7:0];
      end
      unique case (state.phase)
        i2cm_pkg::PH_IDLE: begin
        end
        i2cm_pkg::PH_S_A: begin
          if (over) begin
            state_next.sda_reg = 1'b0;
            state_next.phase   = i2cm_pkg::PH_S_B;
          end
        end
        i2cm_pkg::PH_S_B: begin
          if (over) begin
            state_next.scl_reg = 1'b0;
            state_next.phase   = i2cm_pkg::PH_IDLE;
            done               = 1'b1;
          end
        end
        i2cm_pkg::PH_P_A: begin
          if (over) begin
            state_next.scl_reg = 1'b1;
            state_next.phase   = i2cm_pkg::PH_P_B;
          end
        end
        i2cm_pkg::PH_F_A: begin
          if (over) begin
            state_next.scl_reg = 1'b1;
            state_next.phase   = i2cm_pkg::PH_F_B;
          end
        end
        i2cm_pkg::PH_P_B, i2cm_pkg::PH_F_B: begin
          if (over) begin
            state_next.sda_reg = 1'b1;
            state_next.phase   = i2cm_pkg::PH_IDLE;
            done               = 1'b1;
          end
        end
        i2cm_pkg::PH_W_SET: begin
          if (over) begin
            state_next.scl_reg = 1'b1;
            state_next.phase   = i2cm_pkg::PH_W_HI;
          end
        end
        i2cm_pkg::PH_W_HI: begin
          if (over) begin
            state_next.scl_reg = 1'b0;
            state_next.phase   = i2cm_pkg::PH_W_LO;
          end
        end
        i2cm_pkg::PH_W_LO: begin
          if (over) begin
            state_next.bit_count = bit_inc;
            state_next.shift_reg = shift_w;
            if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
              state_next.sda_dir = 1'b0;
              state_next.sda_reg = 1'b1;
              state_next.phase   = i2cm_pkg::PH_K_SET;
            end else begin
              state_next.sda_reg = shift_w[7];
              state_next.phase   = i2cm_pkg::PH_W_SET;
            end
          end
        end
        i2cm_pkg::PH_K_SET: begin
          if (over) begin
            state_next.scl_reg    = 1'b1;
            state_next.wait_count = 8'd0;
            state_next.phase      = i2cm_pkg::PH_K_WAIT;
          end
        end
        i2cm_pkg::PH_K_WAIT: begin
          if (!sda_in) begin
            state_next.scl_reg    = 1'b0;
            state_next.tick_count = 8'd0;
            state_next.phase      = i2cm_pkg::PH_IDLE;
            done                  = 1'b1;
            ack                   = 1'b1;
          end else begin
            state_next.wait_count = wait_inc;
            // Timed out: pull both lines low and run a stop on our own.
            if (wait_inc >= cfg.ack_timeout) begin
              state_next.sda_dir    = 1'b1;
              state_next.sda_reg    = 1'b0;
              state_next.scl_reg    = 1'b0;
              state_next.tick_count = 8'd0;
              state_next.phase      = i2cm_pkg::PH_F_A;
            end
          end
        end
        i2cm_pkg::PH_R_LO: begin
          if (over) begin
            state_next.scl_reg = 1'b1;
            state_next.phase   = i2cm_pkg::PH_R_HI;
          end
        end
        i2cm_pkg::PH_R_HI: begin
          if (over) begin
            state_next.shift_reg = shift_r;
            state_next.scl_reg   = 1'b0;
            state_next.bit_count = bit_inc;
            if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
              state_next.sda_dir = 1'b1;
              state_next.sda_reg = state.wait_count[0];
              state_next.phase   = i2cm_pkg::PH_A_SET;
            end else begin
              state_next.phase   = i2cm_pkg::PH_R_LO;
            end
          end
        end
        i2cm_pkg::PH_A_SET: begin
          if (over) begin
            state_next.scl_reg = 1'b1;
            state_next.phase   = i2cm_pkg::PH_A_HI;
          end
        end
        i2cm_pkg::PH_A_HI: begin
          if (over) begin
            state_next.scl_reg = 1'b0;
            state_next.phase   = i2cm_pkg::PH_IDLE;
            done               = 1'b1;
            rd                 = state.shift_reg;
          end
        end
      endcase
    end
  end

  always_comb begin
    result.scl_level = state_next.scl_reg;
    result.sda_level = state_next.sda_reg;
    result.sda_drive = state_next.sda_dir;
    result.busy_res  = state_next.phase != i2cm_pkg::PH_IDLE;
    result.done_res  = done;
    result.ack_ok    = ack;
    result.read_data = rd;
    result.rejected  = rej;
  end

endmodule
